### rtl/gibm_pkg.sv
// Package with the shared types and constants of the grouped inode bitmap allocator.
package gibm_pkg;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_DIV,
    ST_POST,
    ST_G_RD,
    ST_G_CHK,
    ST_W_RD,
    ST_W_CHK,
    ST_SET,
    ST_F_RD,
    ST_F_UPD,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_NOFREE  = 2'd1,
    STAT_BADFREE = 2'd2,
    STAT_RSVD    = 2'd3
  } status_e;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [1:0] CFG_GROUP_COUNT = 2'd0;
  localparam logic [1:0] CFG_ITEMS_PER_GROUP = 2'd1;
  localparam logic [1:0] CFG_TOTAL_ITEMS = 2'd2;

  localparam int GCW  = 5;
  localparam int IPGW = 14;
  localparam int NUMW = 18;
  localparam int BASEW = 19;

  localparam logic [GCW-1:0]  GC_RST    = 5'd16;
  localparam logic [IPGW-1:0] IPG_RST   = 14'd8192;
  localparam logic [NUMW-1:0] TOT_RST   = 18'd131072;
  localparam logic [15:0]     FREE_RST  = 16'd8192;
  localparam logic [31:0]     GLOB_RST  = 32'd131072;

  // Bitmap word width; a group occupies a whole number of words.
  localparam int WORD = 32;

endpackage

### rtl/grouped_inode_bitmap_allocator.sv
// Top level of the grouped inode bitmap allocator with its sequencer and stores.
//
//  channel | direction | payload                                  | handshake
//  --------+-----------+------------------------------------------+----------------------
//  in      | in        | func, home_group, item_number, is_dir     | in_valid_i/in_ready_o
//  out     | out       | granted_item, status                      | out_valid_o/out_ready_i
//  cfg     | in        | cfg_index (register), cfg_data            | cfg_valid_i/cfg_ready_o
//
// An 18-step restoring divider runs first (home modulo group count, or item number minus one
// over items per group). An allocate then visits groups from the home group on and reads
// one 32-bit bitmap word at a time, with a read and a check step per group and per word.
// A word may be rejected before the divider or after it. After reset a clearing pass
// writes every one of the GROUPS*ceil(BITS_PER_GROUP/32) bitmap words (4096 at default),
// during which no word is accepted; configuration is taken always. A finished result sits
// in an output register; the next word is taken while it waits.
module grouped_inode_bitmap_allocator #(
  parameter int GROUPS = 16,
  parameter int BITS_PER_GROUP = 8192
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        func_i,
  input  logic [3:0]  home_group_i,
  input  logic [17:0] item_number_i,
  input  logic        is_dir_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [17:0] granted_item_o,
  output logic [1:0]  status_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [17:0] cfg_data_i
);
  import gibm_pkg::*;

  localparam int WPG = (BITS_PER_GROUP + WORD - 1) / WORD;
  localparam int BM_DEPTH = GROUPS * WPG;
  localparam int AW = (BM_DEPTH > 1) ? $clog2(BM_DEPTH) : 1;
  localparam int GW = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int WPW = $clog2(WPG + 1);
  localparam int STORE = GROUPS * BITS_PER_GROUP;

  state_e state_q, state_d;
  logic [AW-1:0]    clr_q, clr_d;
  logic             op_q, op_d, dir_q, dir_d;
  logic [NUMW-1:0]  dvd_q, dvd_d, rem_q, rem_d, quo_q, quo_d;
  logic [IPGW-1:0]  dsr_q, dsr_d;
  logic [4:0]       dcnt_q, dcnt_d;
  logic [GW-1:0]    g_q, g_d;
  logic [GCW-1:0]   k_q, k_d;
  logic [WPW-1:0]   w_q, w_d;
  logic [BASEW-1:0] base_q, base_d;
  logic [IPGW-1:0]  lim_q, lim_d;
  logic [4:0]       idx_q, idx_d;
  logic [NUMW-1:0]  res_gr_q, res_gr_d, out_gr_q, out_gr_d;
  status_e          res_st_q, res_st_d, out_st_q, out_st_d;
  logic             out_valid_q, out_valid_d;
  logic [31:0]      glob_q, glob_d;
  logic [GCW-1:0]   gcnt_q;
  logic [IPGW-1:0]  ipg_q;
  logic [NUMW-1:0]  tot_q;

  logic [WORD-1:0]  bm_mem [BM_DEPTH];
  logic [WORD-1:0]  bm_rd_q, bm_wdata;
  logic             bm_we;
  logic [AW-1:0]    bm_raddr, bm_waddr;
  logic [31:0]      cnt_mem [GROUPS];
  logic [31:0]      cnt_rd_q, cnt_wdata;
  logic             cnt_we;
  logic [GROUPS-1:0] vld_q;
  logic             vld_rd_q;

  logic [GCW-1:0]   gc_eff;
  logic [IPGW-1:0]  ipg_eff;
  logic [NUMW-1:0]  tot_eff;
  logic [15:0]      free_eff, dir_eff;
  logic [NUMW-1:0]  rs;
  logic             ge;
  logic [19:0]      ws, rb;
  logic [WORD-1:0]  cand;
  logic [4:0]       pos;
  logic [BASEW-1:0] diff;

  // Out-of-range register values are clamped into the usable range.
  always_comb begin
    if (gcnt_q == '0) gc_eff = GCW'(1);
    else if (32'(gcnt_q) > GROUPS) gc_eff = GCW'(GROUPS);
    else gc_eff = gcnt_q;
    if (ipg_q == '0) ipg_eff = IPGW'(1);
    else if (32'(ipg_q) > BITS_PER_GROUP) ipg_eff = IPGW'(BITS_PER_GROUP);
    else ipg_eff = ipg_q;
    if (tot_q == '0) tot_eff = NUMW'(1);
    else if (32'(tot_q) > STORE) tot_eff = NUMW'(STORE);
    else tot_eff = tot_q;
  end

  assign free_eff = vld_rd_q ? cnt_rd_q[31:16] : FREE_RST;
  assign dir_eff  = vld_rd_q ? cnt_rd_q[15:0] : 16'd0;

  assign rs = {rem_q[NUMW-2:0], dvd_q[NUMW-1]};
  assign ge = rs >= NUMW'(dsr_q);

  assign ws = 20'(w_q) << 5;
  assign rb = 20'(lim_q) - ws;
  assign diff = BASEW'(tot_eff) - base_q;

  always_comb begin
    pos = '0;
    for (int j = WORD - 1; j >= 0; j--) begin
      cand[j] = !bm_rd_q[j] && (20'(j) < rb);
    end
    for (int j = WORD - 1; j >= 0; j--) begin
      if (cand[j]) pos = 5'(j);
    end
  end

  assign bm_raddr = AW'(g_q * WPG) + AW'(w_q);
  assign bm_waddr = (state_q == ST_CLR) ? clr_q : bm_raddr;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign granted_item_o = out_gr_q;
  assign status_o = out_st_q;

  always_comb begin
    state_d = state_q;
    clr_d = clr_q;
    op_d = op_q;
    dir_d = dir_q;
    dvd_d = dvd_q;
    dsr_d = dsr_q;
    rem_d = rem_q;
    quo_d = quo_q;
    dcnt_d = dcnt_q;
    g_d = g_q;
    k_d = k_q;
    w_d = w_q;
    base_d = base_q;
    lim_d = lim_q;
    idx_d = idx_q;
    res_gr_d = res_gr_q;
    res_st_d = res_st_q;
    out_gr_d = out_gr_q;
    out_st_d = out_st_q;
    out_valid_d = out_valid_q && !out_ready_i;
    glob_d = glob_q;
    bm_we = 1'b0;
    bm_wdata = '0;
    cnt_we = 1'b0;
    cnt_wdata = '0;

    unique case (state_q)
      ST_CLR: begin
        bm_we = 1'b1;
        clr_d = clr_q + AW'(1);
        if (32'(clr_q) == BM_DEPTH - 1) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d = func_i;
          dir_d = is_dir_i;
          rem_d = '0;
          quo_d = '0;
          dcnt_d = 5'(NUMW - 1);
          res_gr_d = '0;
          if (func_i == FUNC_ALLOC) begin
            if (glob_q == '0) begin
              res_st_d = STAT_NOFREE;
              state_d = ST_DONE;
            end else begin
              dvd_d = NUMW'(home_group_i);
              dsr_d = IPGW'(gc_eff);
              state_d = ST_DIV;
            end
          end else begin
            if (item_number_i == '0 || item_number_i > tot_eff) begin
              res_st_d = STAT_BADFREE;
              state_d = ST_DONE;
            end else begin
              dvd_d = item_number_i - NUMW'(1);
              dsr_d = ipg_eff;
              state_d = ST_DIV;
            end
          end
        end
      end
      ST_DIV: begin
        dvd_d = dvd_q << 1;
        rem_d = ge ? rs - NUMW'(dsr_q) : rs;
        quo_d = {quo_q[NUMW-2:0], ge};
        dcnt_d = dcnt_q - 5'd1;
        if (dcnt_q == '0) state_d = ST_POST;
      end
      ST_POST: begin
        if (op_q == FUNC_ALLOC) begin
          g_d = GW'(rem_q);
          k_d = '0;
          state_d = ST_G_RD;
        end else if (quo_q >= NUMW'(gc_eff)) begin
          res_st_d = STAT_BADFREE;
          state_d = ST_DONE;
        end else begin
          g_d = GW'(quo_q);
          w_d = WPW'(rem_q >> 5);
          idx_d = rem_q[4:0];
          state_d = ST_F_RD;
        end
      end
      ST_G_RD: begin
        base_d = BASEW'(g_q * ipg_eff);
        state_d = ST_G_CHK;
      end
      ST_G_CHK, ST_W_RD: begin
        // A group is left when its counter is empty or the scan passes its limit.
        if ((state_q == ST_G_CHK && free_eff == '0) ||
            (state_q == ST_W_RD && ws >= 20'(lim_q))) begin
          if (k_q + GCW'(1) == gc_eff) begin
            res_st_d = STAT_NOFREE;
            state_d = ST_DONE;
          end else begin
            k_d = k_q + GCW'(1);
            g_d = (9'(g_q) + 9'd1 == 9'(gc_eff)) ? '0 : g_q + GW'(1);
            state_d = ST_G_RD;
          end
        end else if (state_q == ST_G_CHK) begin
          if (BASEW'(tot_eff) > base_q) begin
            lim_d = (diff > BASEW'(ipg_eff)) ? ipg_eff : IPGW'(diff);
          end else begin
            lim_d = '0;
          end
          w_d = '0;
          state_d = ST_W_RD;
        end else begin
          state_d = ST_W_CHK;
        end
      end
      ST_W_CHK: begin
        if (|cand) begin
          idx_d = pos;
          state_d = ST_SET;
        end else begin
          w_d = w_q + WPW'(1);
          state_d = ST_W_RD;
        end
      end
      ST_SET: begin
        bm_we = 1'b1;
        bm_wdata = bm_rd_q | (WORD'(1) << idx_q);
        cnt_we = 1'b1;
        cnt_wdata = {free_eff - 16'd1,
                     (dir_q && dir_eff != 16'hFFFF) ? dir_eff + 16'd1 : dir_eff};
        glob_d = glob_q - 32'd1;
        res_gr_d = NUMW'(base_q + BASEW'(ws) + BASEW'(idx_q) + BASEW'(1));
        res_st_d = STAT_OK;
        state_d = ST_DONE;
      end
      ST_F_RD: begin
        state_d = ST_F_UPD;
      end
      ST_F_UPD: begin
        bm_we = 1'b1;
        bm_wdata = bm_rd_q & ~(WORD'(1) << idx_q);
        cnt_we = 1'b1;
        cnt_wdata = {(free_eff != 16'hFFFF) ? free_eff + 16'd1 : free_eff,
                     (dir_q && dir_eff != 16'd0) ? dir_eff - 16'd1 : dir_eff};
        if (glob_q != 32'hFFFF_FFFF) glob_d = glob_q + 32'd1;
        res_st_d = STAT_OK;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_gr_d = res_gr_q;
          out_st_d = res_st_q;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
      clr_q <= '0;
      op_q <= FUNC_ALLOC;
      dir_q <= 1'b0;
      dvd_q <= '0;
      dsr_q <= '0;
      rem_q <= '0;
      quo_q <= '0;
      dcnt_q <= '0;
      g_q <= '0;
      k_q <= '0;
      w_q <= '0;
      base_q <= '0;
      lim_q <= '0;
      idx_q <= '0;
      res_gr_q <= '0;
      res_st_q <= STAT_OK;
      out_gr_q <= '0;
      out_st_q <= STAT_OK;
      out_valid_q <= 1'b0;
      glob_q <= GLOB_RST;
      gcnt_q <= GC_RST;
      ipg_q <= IPG_RST;
      tot_q <= TOT_RST;
      vld_q <= '0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      op_q <= op_d;
      dir_q <= dir_d;
      dvd_q <= dvd_d;
      dsr_q <= dsr_d;
      rem_q <= rem_d;
      quo_q <= quo_d;
      dcnt_q <= dcnt_d;
      g_q <= g_d;
      k_q <= k_d;
      w_q <= w_d;
      base_q <= base_d;
      lim_q <= lim_d;
      idx_q <= idx_d;
      res_gr_q <= res_gr_d;
      res_st_q <= res_st_d;
      out_gr_q <= out_gr_d;
      out_st_q <= out_st_d;
      out_valid_q <= out_valid_d;
      glob_q <= glob_d;
      if (cnt_we) vld_q[g_q] <= 1'b1;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_GROUP_COUNT:     gcnt_q <= cfg_data_i[GCW-1:0];
          CFG_ITEMS_PER_GROUP: ipg_q <= cfg_data_i[IPGW-1:0];
          CFG_TOTAL_ITEMS:     tot_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (bm_we) bm_mem[bm_waddr] <= bm_wdata;
    bm_rd_q <= bm_mem[bm_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) cnt_mem[g_q] <= cnt_wdata;
    cnt_rd_q <= cnt_mem[g_q];
    vld_rd_q <= vld_q[g_q];
  end

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("allocator still ready after taking a word");

  a_no_grant_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != STAT_OK |-> granted_item_o == '0)
    else $error("number granted with a failure status");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o != STAT_RSVD)
    else $error("reserved status code");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> dsr_q != '0)
    else $error("divider started with zero divisor");

  a_alloc_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SET |=> glob_q == $past(glob_q) - 32'd1)
    else $error("global counter not decremented on grant");

endmodule

### bench/tb_top.sv
// Self-checking testbench for the grouped inode bitmap allocator.
module tb_top;
  import gibm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NG = 16;
  localparam int NB = 8192;
  localparam int WATCHDOG_LIMIT = 60000;

  typedef struct packed {
    logic [17:0] granted;
    logic [1:0]  status;
  } grant_t;

  typedef struct packed {
    logic        func;
    logic [3:0]  home;
    logic [17:0] num;
    logic        dir;
    logic        typed;
    logic [17:0] granted;
    logic [1:0]  status;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        func_i = FUNC_ALLOC;
  logic [3:0]  home_group_i = '0;
  logic [17:0] item_number_i = '0;
  logic        is_dir_i = 1'b0;
  logic        out_ready_i = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic [1:0]  cfg_index_i = CFG_GROUP_COUNT;
  logic [17:0] cfg_data_i = '0;
  logic        in_ready_o, out_valid_o, cfg_ready_o;
  logic [17:0] granted_item_o;
  logic [1:0]  status_o;

  grouped_inode_bitmap_allocator u_top (.*);

  always #5 clk_i = ~clk_i;

  // Shadow copy of the allocator state.
  bit          used_map [NG*NB];
  logic [15:0] grp_free [NG];
  logic [15:0] grp_dirs [NG];
  logic [31:0] glob_free;
  logic [4:0]  reg_groups;
  logic [13:0] reg_per_group;
  logic [17:0] reg_total;

  grant_t expected_grants[$];
  int     handed_out[$];
  int     mismatches = 0;
  int     results_seen = 0;
  int     n_alloc = 0, n_free = 0, n_nofree = 0, n_bad = 0;
  int     idle_cycles = 0;
  int     burst_left = 0;

  localparam int NROWS = 12;
  localparam dir_row_t DIRECTED [NROWS] = '{
    '{FUNC_ALLOC, 4'd0,  18'd0,      1'b0, 1'b1, 18'd1,      STAT_OK},
    '{FUNC_ALLOC, 4'd15, 18'd0,      1'b1, 1'b1, 18'd122881, STAT_OK},
    '{FUNC_ALLOC, 4'd3,  18'd0,      1'b0, 1'b1, 18'd24577,  STAT_OK},
    '{FUNC_FREE,  4'd0,  18'd0,      1'b0, 1'b1, 18'd0,      STAT_BADFREE},
    '{FUNC_FREE,  4'd0,  18'd131073, 1'b0, 1'b1, 18'd0,      STAT_BADFREE},
    '{FUNC_FREE,  4'd15, 18'd262143, 1'b1, 1'b1, 18'd0,      STAT_BADFREE},
    '{FUNC_FREE,  4'd0,  18'd1,      1'b1, 1'b1, 18'd0,      STAT_OK},
    '{FUNC_ALLOC, 4'd0,  18'd0,      1'b1, 1'b1, 18'd1,      STAT_OK},
    '{FUNC_FREE,  4'd0,  18'd122881, 1'b1, 1'b1, 18'd0,      STAT_OK},
    '{FUNC_FREE,  4'd0,  18'd5,      1'b0, 1'b1, 18'd0,      STAT_OK},
    '{FUNC_ALLOC, 4'd15, 18'd0,      1'b0, 1'b0, 18'd0,      STAT_OK},
    '{FUNC_FREE,  4'd0,  18'd131072, 1'b0, 1'b0, 18'd0,      STAT_OK}
  };

  // Computes the answer to one request and advances the shadow state.
  function automatic grant_t predict_grant(input logic f, input logic [3:0] home,
                                           input logic [17:0] num, input logic dir);
    int gc, ipg, tot, grp, b, n, k, start;
    bit found;
    grant_t r;
    gc  = (reg_groups == 0) ? 1 : (reg_groups > NG) ? NG : reg_groups;
    ipg = (reg_per_group == 0) ? 1 : (reg_per_group > NB) ? NB : reg_per_group;
    tot = (reg_total == 0) ? 1 : (reg_total > NG*NB) ? NG*NB : reg_total;
    r = '{granted: '0, status: STAT_OK};
    found = 0;
    if (f == FUNC_ALLOC) begin
      r.status = STAT_NOFREE;
      if (glob_free != 0) begin
        start = home % gc;
        for (k = 0; k < gc && !found; k++) begin
          grp = (start + k) % gc;
          if (grp_free[grp] != 0) begin
            for (b = 0; b < ipg; b++) begin
              n = grp*ipg + b + 1;
              if (n > tot) break;
              if (!used_map[grp*NB + b]) begin
                used_map[grp*NB + b] = 1'b1;
                grp_free[grp]--;
                if (dir && grp_dirs[grp] != 16'hFFFF) grp_dirs[grp]++;
                glob_free--;
                r.granted = 18'(n);
                r.status = STAT_OK;
                found = 1;
                break;
              end
            end
          end
        end
      end
    end else begin
      if (num == 0 || num > tot || (num - 1) / ipg >= gc) begin
        r.status = STAT_BADFREE;
      end else begin
        grp = (num - 1) / ipg;
        b = (num - 1) % ipg;
        used_map[grp*NB + b] = 1'b0;
        if (grp_free[grp] != 16'hFFFF) grp_free[grp]++;
        if (dir && grp_dirs[grp] != 0) grp_dirs[grp]--;
        if (glob_free != 32'hFFFF_FFFF) glob_free++;
      end
    end
    return r;
  endfunction

  task automatic send_request(input logic f, input logic [3:0] home, input logic [17:0] num,
                              input logic dir, input bit typed, input grant_t typed_res);
    grant_t r;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap != 0) in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    in_valid_i    <= 1'b1;
    func_i        <= f;
    home_group_i  <= home;
    item_number_i <= num;
    is_dir_i      <= dir;
    do @(posedge clk_i); while (!in_ready_o);
    r = predict_grant(f, home, num, dir);
    if (typed) r = typed_res;
    expected_grants.push_back(r);
    if (f == FUNC_ALLOC && r.status == STAT_OK) handed_out.push_back(int'(r.granted));
    if (f == FUNC_ALLOC) n_alloc++; else n_free++;
    if (r.status == STAT_NOFREE) n_nofree++;
    if (r.status == STAT_BADFREE) n_bad++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [17:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_GROUP_COUNT:     reg_groups = data[4:0];
      CFG_ITEMS_PER_GROUP: reg_per_group = data[13:0];
      default:             reg_total = data;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (expected_grants.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // Result checker, receiver stall pattern and watchdog.
  int stall_mode = 0;
  int stall_cnt = 0;
  always @(posedge clk_i) begin
    grant_t e;
    bit moved;
    moved = (in_valid_i && in_ready_o) || (cfg_valid_i && cfg_ready_o);
    if (out_valid_o && out_ready_i) begin
      moved = 1;
      results_seen++;
      if (expected_grants.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result word: granted %0d status %0d",
                                       granted_item_o, status_o);
      end else begin
        e = expected_grants.pop_front();
        if (e.granted !== granted_item_o || e.status !== status_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected granted %0d status %0d, got granted %0d status %0d",
                     e.granted, e.status, granted_item_o, status_o);
        end
      end
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired with %0d results outstanding", expected_grants.size());
      $display("Simulation FAILED");
      $finish;
    end
    stall_cnt++;
    if (stall_cnt % 64 == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0:       out_ready_i <= 1'b1;
      1:       out_ready_i <= 1'($urandom_range(0, 1));
      default: out_ready_i <= (stall_cnt % 8) < 5;
    endcase
  end

  initial begin
    int p, i, sel, idx, cnt;
    int ph_gc [8] = '{31, 2, 0, 5, 16, 3, 1, 16};
    int ph_ipg[8] = '{16383, 8, 0, 20, 8, 40, 8192, 16};
    int ph_tot[8] = '{262143, 16, 0, 90, 128, 131072, 5, 256};
    reg_groups = GC_RST;
    reg_per_group = IPG_RST;
    reg_total = TOT_RST;
    glob_free = GLOB_RST;
    for (i = 0; i < NG; i++) begin
      grp_free[i] = FREE_RST;
      grp_dirs[i] = '0;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (i = 0; i < NROWS; i++)
      send_request(DIRECTED[i].func, DIRECTED[i].home, DIRECTED[i].num, DIRECTED[i].dir,
                   DIRECTED[i].typed, '{granted: DIRECTED[i].granted,
                                        status: DIRECTED[i].status});
    drain();

    for (p = 0; p < 8; p++) begin
      write_reg(CFG_GROUP_COUNT, 18'(ph_gc[p]));
      write_reg(CFG_ITEMS_PER_GROUP, 18'(ph_ipg[p]));
      write_reg(CFG_TOTAL_ITEMS, 18'(ph_tot[p]));
      cnt = (p == 0) ? 60 : 105;
      for (i = 0; i < cnt; i++) begin
        sel = $urandom_range(0, 99);
        if (sel < 55 || (sel < 85 && handed_out.size() == 0)) begin
          send_request(FUNC_ALLOC, 4'($urandom_range(0, 15)), 18'($urandom_range(0, 18'h3FFFF)),
                       1'($urandom_range(0, 1)), 1'b0, '0);
        end else if (sel < 85) begin
          idx = $urandom_range(0, handed_out.size() - 1);
          send_request(FUNC_FREE, 4'($urandom_range(0, 15)), 18'(handed_out[idx]),
                       1'($urandom_range(0, 1)), 1'b0, '0);
          handed_out.delete(idx);
        end else if (sel < 93) begin
          send_request(FUNC_FREE, 4'($urandom_range(0, 15)), 18'($urandom_range(0, 18'h3FFFF)),
                       1'($urandom_range(0, 1)), 1'b0, '0);
        end else begin
          // Small numbers hit clear bits, the item past the bound, and zero.
          send_request(FUNC_FREE, 4'($urandom_range(0, 15)), 18'($urandom_range(0, 300)),
                       1'($urandom_range(0, 1)), 1'b0, '0);
        end
      end
      drain();
    end

    repeat (100) @(posedge clk_i);
    $display("Covered %0d allocates and %0d frees over 8 register settings.", n_alloc, n_free);
    $display("%0d results checked, %0d nothing-free, %0d bad frees, %0d mismatches.",
             results_seen, n_nofree, n_bad, mismatches);
    if (mismatches == 0 && expected_grants.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
